// ----- src/text_console_cursor_controller_macros.svh -----
// Assertion macros used by the checker of the console controller.
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define TCCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console controller check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define TCCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console controller check failed");

`endif

// ----- src/tccc_pkg.sv -----
package tccc_pkg;

    typedef enum logic [2:0] {
        OP_GLYPH       = 3'd0,
        OP_FILL_CELL   = 3'd1,
        OP_SCROLL      = 3'd2,
        OP_FLUSH       = 3'd3,
        OP_FILL_SCREEN = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KIND_CLEAR   = 3'd0,
        KIND_NEWLINE = 3'd1,
        KIND_CR      = 3'd2,
        KIND_TAB     = 3'd3,
        KIND_BKSP    = 3'd4,
        KIND_GLYPH   = 3'd5
    } kind_t;

    localparam logic [1:0] REG_ENABLE     = 2'd0;
    localparam logic [1:0] REG_COLUMNS    = 2'd1;
    localparam logic [1:0] REG_TEXT_ROWS  = 2'd2;
    localparam logic [1:0] REG_GLYPH_MODE = 2'd3;

    localparam logic [7:0] RESET_COLUMNS   = 8'd80;
    localparam logic [7:0] RESET_TEXT_ROWS = 8'd25;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    localparam logic [7:0] FIRST_PRINTABLE   = 8'h20;
    localparam logic [7:0] LAST_PRINTABLE    = 8'h7E;
    localparam logic [7:0] PLACEHOLDER_ENTRY = 8'd2;
    localparam logic [8:0] TAB_WIDTH         = 9'd4;

    typedef struct packed {
        logic       enable;
        logic [7:0] columns;
        logic [7:0] text_rows;
        logic       glyph_cache_mode;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] font;
    } cls_item_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] font;
        logic       last;
    } res_t;

endpackage

// ----- src/tccc_cfg.sv -----
module tccc_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output tccc_pkg::cfg_t cfg
);
    import tccc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_ENABLE:     cfg_next.enable           = pwdata[0];
                REG_COLUMNS:    cfg_next.columns          = pwdata[7:0];
                REG_TEXT_ROWS:  cfg_next.text_rows        = pwdata[7:0];
                REG_GLYPH_MODE: cfg_next.glyph_cache_mode = pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENABLE:     prdata = {31'd0, cfg_reg.enable};
            REG_COLUMNS:    prdata = {24'd0, cfg_reg.columns};
            REG_TEXT_ROWS:  prdata = {24'd0, cfg_reg.text_rows};
            REG_GLYPH_MODE: prdata = {31'd0, cfg_reg.glyph_cache_mode};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable           <= 1'b0;
            cfg_reg.columns          <= RESET_COLUMNS;
            cfg_reg.text_rows        <= RESET_TEXT_ROWS;
            cfg_reg.glyph_cache_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/tccc_front.sv -----
module tccc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  tccc_pkg::cfg_t      cfg,
    input  logic                push,
    output logic                full,
    input  logic                cmd,
    input  logic [7:0]          char_code,
    output logic                q_valid,
    output tccc_pkg::cls_item_t q_item,
    input  logic                q_pop
);
    import tccc_pkg::*;

    cls_item_t mem [2];
    cls_item_t cls;
    logic      wr_ptr_reg, wr_ptr_next;
    logic      rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic      accept;
    logic      keep;
    logic      do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem[rd_ptr_reg];
    assign accept  = push && !full;
    assign do_pop  = q_pop && q_valid;

    // Drop items while disabled, and NUL bytes: they change nothing.
    assign keep = cfg.enable && (cmd || (char_code != CH_NUL));

    always_comb
    begin
        cls.font = char_code;
        if (cfg.glyph_cache_mode &&
            ((char_code < FIRST_PRINTABLE) || (char_code > LAST_PRINTABLE)))
        begin
            cls.font = PLACEHOLDER_ENTRY;
        end
        if (cmd)
        begin
            cls.kind = KIND_CLEAR;
        end
        else
        begin
            unique case (char_code)
                CH_NEWLINE:   cls.kind = KIND_NEWLINE;
                CH_RETURN:    cls.kind = KIND_CR;
                CH_TAB:       cls.kind = KIND_TAB;
                CH_BACKSPACE: cls.kind = KIND_BKSP;
                default:      cls.kind = KIND_GLYPH;
            endcase
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept && keep)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        unique case ({accept && keep, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/tccc_back.sv -----
module tccc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tccc_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  tccc_pkg::cls_item_t q_item,
    output logic                q_pop,
    output logic                res_valid,
    output tccc_pkg::res_t      res,
    input  logic                res_ready
);
    import tccc_pkg::*;

    // Pending results of an item: bit 0 cell or screen op, bit 1 scroll, bit 2 flush.
    logic [2:0] pend_reg, pend_next;
    logic [2:0] pend_after;
    logic [2:0] pend_rest;
    logic [2:0] new_pend;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    op_t        first_op_reg, first_op_next;
    logic [7:0] first_col_reg, first_col_next;
    logic [7:0] first_row_reg, first_row_next;
    logic [7:0] first_font_reg, first_font_next;

    logic [8:0] cols9, rows9;
    logic [8:0] m, n, m2, n2;
    logic       has_first;
    logic       wrap;
    logic       scroll;
    logic       emit_fire;
    logic       load;

    assign cols9 = {1'b0, (cfg.columns == 8'd0) ? 8'd1 : cfg.columns};
    assign rows9 = {1'b0, (cfg.text_rows == 8'd0) ? 8'd1 : cfg.text_rows};

    // Cursor update and result set for the item at the head of the queue.
    always_comb
    begin
        m               = {1'b0, col_reg};
        n               = {1'b0, row_reg};
        has_first       = 1'b0;
        first_op_next   = OP_GLYPH;
        first_col_next  = 8'd0;
        first_row_next  = 8'd0;
        first_font_next = 8'd0;
        unique case (q_item.kind)
            KIND_NEWLINE:
            begin
                m = 9'd0;
                n = n + 9'd1;
            end
            KIND_CR:
            begin
                m = 9'd0;
            end
            KIND_TAB:
            begin
                m = m + TAB_WIDTH;
            end
            KIND_BKSP:
            begin
                if (m != 9'd0)
                begin
                    m         = m - 9'd1;
                    has_first = 1'b1;
                end
                else if (n != 9'd0)
                begin
                    n         = n - 9'd1;
                    m         = cols9 - 9'd1;
                    has_first = 1'b1;
                end
                first_op_next  = OP_FILL_CELL;
                first_col_next = m[7:0];
                first_row_next = n[7:0];
            end
            KIND_GLYPH:
            begin
                has_first       = 1'b1;
                first_col_next  = m[7:0];
                first_row_next  = n[7:0];
                first_font_next = q_item.font;
                m               = m + 9'd1;
            end
            KIND_CLEAR:
            begin
                first_op_next = OP_FILL_SCREEN;
            end
            default:
            begin
                m = {1'b0, col_reg};
            end
        endcase

        wrap   = (m >= cols9);
        m2     = wrap ? 9'd0 : m;
        n2     = wrap ? (n + 9'd1) : n;
        scroll = (n2 >= rows9);
        if (scroll)
        begin
            n2 = rows9 - 9'd1;
        end

        if (q_item.kind == KIND_CLEAR)
        begin
            new_pend = 3'b101;
            m2       = 9'd0;
            n2       = 9'd0;
        end
        else
        begin
            new_pend = {scroll, scroll, has_first};
        end
    end

    // Emit the lowest pending result; a single pending bit marks the last one.
    assign pend_rest = pend_reg & (pend_reg - 3'd1);
    assign res_valid = (pend_reg != 3'd0);
    assign emit_fire = res_valid && res_ready;
    assign pend_after = emit_fire ? pend_rest : pend_reg;
    assign load      = q_valid && (pend_after == 3'd0);
    assign q_pop     = load;

    always_comb
    begin
        res.col  = 8'd0;
        res.row  = 8'd0;
        res.font = 8'd0;
        res.last = (pend_rest == 3'd0);
        priority if (pend_reg[0])
        begin
            res.op   = first_op_reg;
            res.col  = first_col_reg;
            res.row  = first_row_reg;
            res.font = first_font_reg;
        end
        else if (pend_reg[1])
        begin
            res.op = OP_SCROLL;
        end
        else
        begin
            res.op = OP_FLUSH;
        end
    end

    always_comb
    begin
        pend_next = pend_after;
        col_next  = col_reg;
        row_next  = row_reg;
        if (load)
        begin
            pend_next = new_pend;
            col_next  = m2[7:0];
            row_next  = n2[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            first_op_reg   <= first_op_next;
            first_col_reg  <= first_col_next;
            first_row_reg  <= first_row_next;
            first_font_reg <= first_font_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
            col_reg  <= 8'd0;
            row_reg  <= 8'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule

// ----- src/tccc_outq.sv -----
module tccc_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    input  tccc_pkg::res_t wr_data,
    output logic           wr_ready,
    output logic           empty,
    input  logic           pop,
    output tccc_pkg::res_t rd_data
);
    import tccc_pkg::*;

    res_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/text_console_cursor_controller.sv -----
// Text console cursor controller.
// Input channel (push/full): one item is a clear command or a character byte.
// The front end classifies it and places it in a two-entry command queue;
// disabled-console items and NUL bytes are dropped there.
// The back end keeps the cursor and turns each item into zero to three draw
// commands (cell op, scroll, flush; or fill screen, flush), one per cycle
// while the result queue has room. Result channel (empty/pop): a two-entry
// result queue; last marks the final command of an item.
// The first result of an item passes the command queue, the pending result
// registers of the back end and the result queue before it is on the ports.
// The back end loads the next item in the same cycle as it hands on the last
// result of the current one, or at once when it has no result pending.
// When the receiver stalls, the result queue fills, then the back end holds,
// then the command queue fills and full rises; nothing is lost.
// Reset empties both queues, homes the cursor and loads the register reset
// values (disabled, 80 columns, 25 rows, glyph cache off).
// Configuration: APB registers enable, columns, text_rows, glyph_cache_mode
// at byte addresses 0, 4, 8, 12; write only while the block is idle.
module text_console_cursor_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        cmd,
    input  logic [7:0]  char_code,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  op,
    output logic [7:0]  cell_col,
    output logic [7:0]  cell_row,
    output logic [7:0]  font_entry,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tccc_pkg::*;

    cfg_t      cfg;
    logic      q_valid;
    cls_item_t q_item;
    logic      q_pop;
    logic      res_valid;
    res_t      res;
    logic      res_ready;
    res_t      head;

    tccc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tccc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .char_code (char_code),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    tccc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    tccc_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .wr_ready (res_ready),
        .empty    (empty),
        .pop      (pop),
        .rd_data  (head)
    );

    assign op         = head.op;
    assign cell_col   = head.col;
    assign cell_row   = head.row;
    assign font_entry = head.font;
    assign last       = head.last;

endmodule

// ----- src/tccc_checker.sv -----
`include "text_console_cursor_controller_macros.svh"

module tccc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] op,
    input logic [7:0] cell_col,
    input logic [7:0] cell_row,
    input logic [7:0] font_entry,
    input logic       last
);
    import tccc_pkg::*;

    // Flush always closes an item.
    `TCCC_ASSERT_NOW(a_flush_last, clk, rst_n, !empty && (op == OP_FLUSH), last)
    // Scroll and fill screen are always followed by a flush.
    `TCCC_ASSERT_NOW(a_not_last, clk, rst_n,
        !empty && ((op == OP_SCROLL) || (op == OP_FILL_SCREEN)), !last)
    // Whole-screen commands carry no cell or font.
    `TCCC_ASSERT_NOW(a_zero_fields, clk, rst_n,
        !empty && ((op == OP_SCROLL) || (op == OP_FLUSH) || (op == OP_FILL_SCREEN)),
        (cell_col == 8'd0) && (cell_row == 8'd0) && (font_entry == 8'd0))
    // Hold a stalled result.
    `TCCC_ASSERT_NEXT(a_stall_hold, clk, rst_n, !empty && !pop,
        !empty && $stable(op) && $stable(cell_col) && $stable(cell_row)
        && $stable(font_entry) && $stable(last))

endmodule

bind text_console_cursor_controller tccc_checker u_tccc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .op         (op),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .font_entry (font_entry),
    .last       (last)
);
